@@ src/atc_pkg.sv @@
// Shared types, widths and constants of the ADC thermistor temperature converter.
// Holds the item tag, the result kind codes, the register indexes and the ln table.
// No dependencies.
package atc_pkg;

    localparam int CODE_BITS = 24;
    localparam int FRAC_BITS = 8;

    localparam int ADC_W  = 32;
    localparam int MUX_W  = 16;
    localparam int STAT_W = 8;
    localparam int CFG_W  = 16;
    localparam int OUT_W  = 24;
    localparam int C_W    = 24;   // code scaled to 24 bits
    localparam int LN_W   = 21;   // ln of a 24-bit value in Q16
    localparam int L_W    = 23;   // signed log ratio in Q16
    localparam int CQ_W   = 40;   // signed Celsius value in Q24

    localparam int MID_LAT = 7;   // tag delay depth, from the decode register to the Q24 Celsius value

    localparam int LN2_Q16  = 45426;
    localparam int LN_K_Q16 = -85445;
    localparam int OUT_MAX  = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN  = -(1 << (OUT_W - 1));

    localparam logic [1:0] CFG_STATUS    = 2'd0;
    localparam logic [1:0] CFG_THERM_MUX = 2'd1;
    localparam logic [1:0] CFG_INT_MUX   = 2'd2;

    typedef enum logic [2:0] {
        KIND_INVALID  = 3'd0,
        KIND_STALE    = 3'd1,
        KIND_THERM    = 3'd2,
        KIND_INTERNAL = 3'd3,
        KIND_UNKNOWN  = 3'd4,
        KIND_DOMAIN   = 3'd5
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_tag;

    // ln(1 + k/16) in Q16 for k = 0..16.
    function automatic logic [15:0] ln_frac(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3973;
            5'd2:    v = 16'd7719;
            5'd3:    v = 16'd11262;
            5'd4:    v = 16'd14624;
            5'd5:    v = 16'd17821;
            5'd6:    v = 16'd20870;
            5'd7:    v = 16'd23783;
            5'd8:    v = 16'd26573;
            5'd9:    v = 16'd29248;
            5'd10:   v = 16'd31818;
            5'd11:   v = 16'd34292;
            5'd12:   v = 16'd36675;
            5'd13:   v = 16'd38975;
            5'd14:   v = 16'd41196;
            5'd15:   v = 16'd43345;
            5'd16:   v = 16'd45426;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ src/atc_ln.sv @@
// Three-stage natural logarithm in Q16 of a 24-bit unsigned value.
// Normalize, table lookup with interpolation product, then sum.
// Depends on atc_pkg.
module atc_ln
    import atc_pkg::*;
(
    input  logic            i_clk,
    input  logic [C_W-1:0]  i_n,
    output logic [LN_W-1:0] o_ln
);

    logic [4:0]      n_e;
    logic [C_W-1:0]  n_sh;
    logic [4:0]      r_e;
    logic [3:0]      r_idx;
    logic [18:0]     r_rem;

    logic [15:0]     n_t0;
    logic [15:0]     n_t1;
    logic [11:0]     n_diff;
    logic [30:0]     n_prod;
    logic [LN_W-1:0] n_base;
    logic [30:0]     r_prod;
    logic [LN_W-1:0] r_base;
    logic [LN_W-1:0] r_ln;

    // Leading one position and normalized mantissa.
    always_comb begin
        n_e = '0;
        for (int i = 0; i < C_W; i++) begin
            if (i_n[i]) begin
                n_e = 5'(i);
            end
        end
        n_sh = i_n << (5'(C_W - 1) - n_e);
    end

    always_ff @(posedge i_clk) begin
        r_e   <= n_e;
        r_idx <= n_sh[C_W-2:C_W-5];
        r_rem <= n_sh[18:0];
    end

    always_comb begin
        n_t0   = ln_frac({1'b0, r_idx});
        n_t1   = ln_frac({1'b0, r_idx} + 5'd1);
        n_diff = 12'(n_t1 - n_t0);
        n_prod = 31'(n_diff) * 31'(r_rem);
        n_base = LN_W'(r_e) * LN_W'(LN2_Q16) + LN_W'(n_t0);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_base <= n_base;
        r_ln   <= r_base + LN_W'(r_prod[30:19]);
    end

    assign o_ln = r_ln;

endmodule

@@ src/atc_int.sv @@
// Seven-stage internal diode transfer: Celsius in Q24 from the signed code.
// Exact truncating division by 34375 done with reciprocal multiplies.
// Depends on atc_pkg.
module atc_int
    import atc_pkg::*;
(
    input  logic                   i_clk,
    input  logic [C_W-1:0]         i_c,
    output logic signed [CQ_W-1:0] o_cq
);

    // c * 133 * 2^24 / 137500 reduces to c * 133 * 2^22 / 34375.
    localparam int INT_GAIN  = 133;
    localparam int INT_DIV   = 34375;
    localparam int INT_WHOLE = (1 << 22) / INT_DIV;
    localparam int INT_REM   = (1 << 22) % INT_DIV;
    localparam logic [63:0] INT_M1  = ((64'd1 << 47) + 64'(INT_DIV - 1)) / 64'(INT_DIV);
    localparam logic [63:0] INT_M2  = ((64'd1 << 42) + 64'(INT_DIV - 1)) / 64'(INT_DIV);
    localparam logic [63:0] INT_OFF = (64'd267147 << 24) / 64'd1000;

    logic [C_W-1:0] n_mag;
    logic [63:0]    n_p1;
    logic [51:0]    n_p2;
    logic signed [CQ_W-1:0] n_qs;

    logic [5:0]  r_neg;
    logic [31:0] r_y;
    logic [31:0] r_y2;
    logic [15:0] r_a2;
    logic [15:0] r_a3;
    logic [15:0] r_a4;
    logic [15:0] r_a5;
    logic [15:0] r_b;
    logic [24:0] r_w;
    logic [22:0] r_g4;
    logic [22:0] r_g5;
    logic [9:0]  r_f;
    logic [37:0] r_q;
    logic signed [CQ_W-1:0] r_cq;

    always_comb begin
        n_mag = i_c[C_W-1] ? (~i_c + 1'b1) : i_c;
        n_p1  = 64'(r_y) * INT_M1;
        n_p2  = 52'(r_w) * 52'(INT_M2);
        n_qs  = CQ_W'(r_q);
    end

    always_ff @(posedge i_clk) begin
        r_neg <= {r_neg[4:0], i_c[C_W-1]};
        r_y   <= 32'(n_mag) * 32'(INT_GAIN);
        // Quotient and remainder of y by 34375.
        r_a2  <= 16'(n_p1 >> 47);
        r_y2  <= r_y;
        r_b   <= 16'(r_y2 - 32'(r_a2) * 32'(INT_DIV));
        r_a3  <= r_a2;
        // Remainder times 2^22 / 34375 splits into a whole and a fractional part.
        r_w   <= 25'(r_b) * 25'(INT_REM);
        r_g4  <= 23'(r_b) * 23'(INT_WHOLE);
        r_a4  <= r_a3;
        r_f   <= 10'(n_p2 >> 42);
        r_g5  <= r_g4;
        r_a5  <= r_a4;
        r_q   <= (38'(r_a5) << 22) + 38'(r_g5) + 38'(r_f);
        r_cq  <= r_neg[5] ? (-n_qs - CQ_W'(INT_OFF)) : (n_qs - CQ_W'(INT_OFF));
    end

    assign o_cq = r_cq;

endmodule

@@ src/atc_tscale.sv @@
// Four-stage thermistor scaling: Celsius in Q24 from the two logarithms.
// Computes -(L * 2403 * 256) / 100 truncated, with L the log of the divider ratio.
// Depends on atc_pkg.
module atc_tscale
    import atc_pkg::*;
(
    input  logic                   i_clk,
    input  logic [LN_W-1:0]        i_lnc,
    input  logic [LN_W-1:0]        i_lnd,
    output logic signed [CQ_W-1:0] o_cq
);

    // 2403 * 256 / 100 reduces to 153792 / 25 = 6151 + 17 / 25.
    localparam int THERM_NUM   = 2403 * 256 / 4;
    localparam int THERM_DEN   = 25;
    localparam int THERM_WHOLE = THERM_NUM / THERM_DEN;
    localparam int THERM_REM   = THERM_NUM % THERM_DEN;
    localparam logic [51:0] THERM_M = ((52'd1 << 30) + 52'(THERM_DEN - 1)) / 52'(THERM_DEN);

    logic signed [L_W-1:0] n_l;
    logic [LN_W-1:0]       n_mag;
    logic [51:0]           n_pr;
    logic [34:0]           n_q;

    logic [2:0]      r_pos;
    logic [LN_W-1:0] r_mag;
    logic [33:0]     r_p1;
    logic [33:0]     r_p1b;
    logic [25:0]     r_p2;
    logic [21:0]     r_f;
    logic signed [CQ_W-1:0] r_cq;

    always_comb begin
        n_l   = L_W'(LN_K_Q16) + L_W'(i_lnc) - L_W'(i_lnd);
        n_mag = LN_W'(n_l[L_W-1] ? -n_l : n_l);
        n_pr  = 52'(r_p2) * THERM_M;
        n_q   = 35'(r_p1b) + 35'(r_f);
    end

    // The result is positive when the log ratio is negative.
    always_ff @(posedge i_clk) begin
        r_pos <= {r_pos[1:0], n_l[L_W-1]};
        r_mag <= n_mag;
        r_p1  <= 34'(r_mag) * 34'(THERM_WHOLE);
        r_p2  <= 26'(r_mag) * 26'(THERM_REM);
        r_f   <= 22'(n_pr >> 30);
        r_p1b <= r_p1;
        r_cq  <= r_pos[2] ? signed'(CQ_W'(n_q)) : -signed'(CQ_W'(n_q));
    end

    assign o_cq = r_cq;

endmodule

@@ src/atc_fmt.sv @@
// Five-stage output formatter: Q24 Celsius to saturated Q8 Celsius and Fahrenheit.
// The divide by 5 runs as three long-division digits; holds the output registers.
// Depends on atc_pkg.
module atc_fmt
    import atc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tag                   i_tag,
    input  logic signed [CQ_W-1:0] i_cq,
    output logic                   o_done,
    output t_kind                  o_kind,
    output logic [OUT_W-1:0]       o_temp_c,
    output logic [OUT_W-1:0]       o_temp_f
);

    localparam int SHIFT = 24 - FRAC_BITS;
    localparam int V_W   = 42;
    localparam int RND   = 1 << (SHIFT - 1);
    localparam logic [V_W-1:0] OFFR = (V_W'(32) << 24) + V_W'(RND);
    localparam logic [42:0] DIV5_M = ((43'd1 << 24) + 43'd4) / 43'd5;

    function automatic logic [OUT_W-1:0] to_field(input logic signed [V_W-1:0] v);
        logic signed [V_W-1:0] t;
        logic [OUT_W-1:0]      f;
        t = v >>> SHIFT;
        if (t > V_W'(OUT_MAX)) begin
            f = OUT_W'(OUT_MAX);
        end else if (t < V_W'(OUT_MIN)) begin
            f = OUT_W'(OUT_MIN);
        end else begin
            f = OUT_W'(t);
        end
        return f;
    endfunction

    // Exact floor(z / 5) for z below 2^22.
    function automatic logic [20:0] div5(input logic [20:0] z);
        logic [42:0] p;
        p = 43'(z) * DIV5_M;
        return 21'(p >> 24);
    endfunction

    logic                   n_temp;
    logic [CQ_W-1:0]        n_mag;
    logic [20:0]            n_q1;
    logic [20:0]            n_q2;
    logic [20:0]            n_q3;
    logic [20:0]            n_z2;
    logic [20:0]            n_z3;
    logic signed [V_W-1:0]  n_fv;

    t_tag             r_tag [4];
    logic [OUT_W-1:0] r_cel [4];
    logic [3:0]       r_neg;
    logic [41:0]      r_a9;
    logic [3:0]       r_q1 [2];
    logic [2:0]       r_r1;
    logic [35:0]      r_low;
    logic [17:0]      r_q2;
    logic [2:0]       r_r2;
    logic [17:0]      r_lo;
    logic [39:0]      r_fmag;
    logic             r_done;
    t_kind            r_kind;
    logic [OUT_W-1:0] r_out_c;
    logic [OUT_W-1:0] r_out_f;

    always_comb begin
        n_temp = (i_tag.kind == KIND_THERM) || (i_tag.kind == KIND_INTERNAL);
        n_mag  = i_cq[CQ_W-1] ? CQ_W'(-i_cq) : CQ_W'(i_cq);
        n_q1   = div5(21'(r_a9[41:36]));
        n_z2   = {r_r1, r_low[35:18]};
        n_q2   = div5(n_z2);
        n_z3   = {r_r2, r_lo};
        n_q3   = div5(n_z3);
        n_fv   = r_neg[3] ? signed'(OFFR - V_W'(r_fmag)) : signed'(OFFR + V_W'(r_fmag));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_tag[i].valid <= 1'b0;
            end
            r_done <= 1'b0;
        end else begin
            r_tag[0] <= i_tag;
            for (int i = 1; i < 4; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
            r_done <= r_tag[3].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cel[0] <= n_temp ? to_field(V_W'(i_cq) + V_W'(RND)) : '0;
        for (int i = 1; i < 4; i++) begin
            r_cel[i] <= r_cel[i-1];
        end
        r_neg <= {r_neg[2:0], i_cq[CQ_W-1]};
        r_a9  <= 42'(n_mag) * 42'(9);
        // First digit: top six bits of 9 * |C|.
        r_q1[0] <= 4'(n_q1);
        r_r1    <= 3'(21'(r_a9[41:36]) - n_q1 * 21'(5));
        r_low   <= r_a9[35:0];
        r_q1[1] <= r_q1[0];
        r_q2    <= 18'(n_q2);
        r_r2    <= 3'(n_z2 - n_q2 * 21'(5));
        r_lo    <= r_low[17:0];
        r_fmag  <= {r_q1[1], r_q2, 18'(n_q3)};
        r_kind  <= r_tag[3].kind;
        r_out_c <= r_cel[3];
        if ((r_tag[3].kind == KIND_THERM) || (r_tag[3].kind == KIND_INTERNAL)) begin
            r_out_f <= to_field(n_fv);
        end else begin
            r_out_f <= '0;
        end
    end

    assign o_done   = r_done;
    assign o_kind   = r_kind;
    assign o_temp_c = r_out_c;
    assign o_temp_f = r_out_f;

endmodule

@@ src/adc_thermistor_temperature_convert.sv @@
// One ADC read word goes in per cycle while busy is low, and its result comes out
// in order, on a one-cycle o_done strobe; the receiver cannot stall, so every accepted
// word always yields one result. The path is the decode register, the three-stage
// logarithm and four-stage scaling (matched by the seven-stage internal diode path) and
// the five-stage output formatter with its digit-by-digit divide by five. busy is high
// during reset and for the first cycle after it. Write configuration only while no word
// is in flight.
module adc_thermistor_temperature_convert
    import atc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ADC_W-1:0]  i_adc_word,
    input  logic [MUX_W-1:0]  i_mux_word,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_done,
    output logic [2:0]        o_kind,
    output logic [OUT_W-1:0]  o_temp_celsius_q8,
    output logic [OUT_W-1:0]  o_temp_fahrenheit_q8
);

    logic              r_busy;
    logic [STAT_W-1:0] r_exp_status;
    logic [MUX_W-1:0]  r_therm_mux;
    logic [MUX_W-1:0]  r_int_mux;

    logic              n_full;
    logic [C_W-1:0]    n_c;
    logic [C_W-1:0]    n_d;
    logic              n_nonpos;
    t_kind             n_kind;

    t_tag              r_tag;
    logic [C_W-1:0]    r_c;
    logic [C_W-1:0]    r_d;
    t_tag              r_dly [MID_LAT];

    logic [LN_W-1:0]        lnc;
    logic [LN_W-1:0]        lnd;
    logic signed [CQ_W-1:0] therm_cq;
    logic signed [CQ_W-1:0] int_cq;
    logic signed [CQ_W-1:0] n_cq;
    t_kind                  out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_exp_status <= STAT_W'(19);
            r_therm_mux  <= MUX_W'(16'h1701);
            r_int_mux    <= MUX_W'(16'h17DE);
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_STATUS:    r_exp_status <= i_cfg_data[STAT_W-1:0];
                    CFG_THERM_MUX: r_therm_mux  <= i_cfg_data;
                    CFG_INT_MUX:   r_int_mux    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign busy = r_busy;

    always_comb begin
        n_full   = &i_adc_word[CODE_BITS-1:1];
        n_c      = C_W'(i_adc_word[CODE_BITS-1:0]) << (C_W - CODE_BITS);
        n_d      = C_W'(1 << (C_W - 1)) - n_c;
        n_nonpos = n_c[C_W-1] || (n_c == '0);
        if (n_full) begin
            n_kind = KIND_INVALID;
        end else if (i_adc_word[ADC_W-1:ADC_W-STAT_W] != r_exp_status) begin
            n_kind = KIND_STALE;
        end else if (i_mux_word == r_therm_mux) begin
            n_kind = n_nonpos ? KIND_DOMAIN : KIND_THERM;
        end else if (i_mux_word == r_int_mux) begin
            n_kind = KIND_INTERNAL;
        end else begin
            n_kind = KIND_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
            for (int i = 0; i < MID_LAT; i++) begin
                r_dly[i].valid <= 1'b0;
            end
        end else begin
            r_tag.valid <= start && !r_busy;
            r_tag.kind  <= n_kind;
            r_dly[0]    <= r_tag;
            for (int i = 1; i < MID_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
        r_d <= n_d;
    end

    atc_ln u_ln_c (
        .i_clk (i_clk),
        .i_n   (r_c),
        .o_ln  (lnc)
    );

    atc_ln u_ln_d (
        .i_clk (i_clk),
        .i_n   (r_d),
        .o_ln  (lnd)
    );

    atc_tscale u_tscale (
        .i_clk (i_clk),
        .i_lnc (lnc),
        .i_lnd (lnd),
        .o_cq  (therm_cq)
    );

    atc_int u_int (
        .i_clk (i_clk),
        .i_c   (r_c),
        .o_cq  (int_cq)
    );

    assign n_cq = (r_dly[MID_LAT-1].kind == KIND_INTERNAL) ? int_cq : therm_cq;

    atc_fmt u_fmt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (r_dly[MID_LAT-1]),
        .i_cq     (n_cq),
        .o_done   (o_done),
        .o_kind   (out_kind),
        .o_temp_c (o_temp_celsius_q8),
        .o_temp_f (o_temp_fahrenheit_q8)
    );

    assign o_kind = out_kind;

endmodule

@@ src/atc_chk.sv @@
// Port-level checker for the temperature converter, bound to the top level.
// Checks that results match accepted words and zero temperatures on non-temperature kinds.
// Depends on atc_pkg.
module atc_chk
    import atc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input logic [2:0]       o_kind,
    input logic [OUT_W-1:0] o_temp_celsius_q8,
    input logic [OUT_W-1:0] o_temp_fahrenheit_q8
);

    // Every accepted word gives a result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##13 o_done)
        else $error("accepted word produced no result after 13 cycles");

    // No result appears without a matching accepted word.
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 13))
        else $error("result without a matching accepted word");

    // Only thermistor and internal diode results carry temperatures.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_kind != KIND_THERM) && (o_kind != KIND_INTERNAL))
        |-> ((o_temp_celsius_q8 == '0) && (o_temp_fahrenheit_q8 == '0)))
        else $error("temperature nonzero on a non-temperature result");

endmodule

bind adc_thermistor_temperature_convert atc_chk u_atc_chk (.*);
